// ===== rtl/core/rfft_pkg.sv =====
package rfft_pkg;

   localparam int MAX_LOG2    = 12;
   localparam int MAX_POINTS  = 1 << MAX_LOG2;
   localparam int HALF_POINTS = MAX_POINTS / 2;
   localparam int TW_FRAC     = 17;
   localparam real PI_VALUE   = 3.14159265359;

   localparam logic [3:0] LOG2_RESET = 4'd10;
   localparam logic       REG_LOG2   = 1'b0;
   localparam logic       REG_INV    = 1'b1;

   typedef logic [37:0] tw_rom_type [HALF_POINTS];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_CP_RD,
      ST_CP_WR,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_ADD,
      ST_BF_WU,
      ST_BF_WV,
      ST_SC_RD,
      ST_SC_WR
   } state_type;

   typedef enum logic [1:0] {
      WSEL_COPY,
      WSEL_BF_U,
      WSEL_BF_V,
      WSEL_SCALE
   } wsel_type;

   typedef struct packed {
      logic        load_we;
      logic [11:0] load_wa;
      logic        load_re;
      logic [11:0] load_ra;
      logic        work_re;
      logic [11:0] work_ra;
      logic [11:0] work_rb;
      logic        work_we;
      logic [11:0] work_wa;
      wsel_type    wsel;
      logic        tw_re;
      logic [10:0] tw_addr;
      logic        mul_en;
      logic        add_en;
      logic        out_load;
      logic [11:0] out_index;
      logic        out_last;
      logic [3:0]  shift;
      logic        inverse;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   function automatic tw_rom_type build_tw_rom();
      tw_rom_type rom;
      real ang;
      int c;
      int s;
      for (int k = 0; k < HALF_POINTS; k++) begin
         ang = 2.0 * PI_VALUE * k / MAX_POINTS;
         c = $rtoi($floor($cos(ang) * 131072.0 + 0.5));
         s = $rtoi($floor($sin(ang) * 131072.0 + 0.5));
         rom[k] = {19'(s), 19'(c)};
      end
      return rom;
   endfunction

   function automatic logic signed [17:0] sat_tw(input logic signed [19:0] v);
      if (v > 20'sd131071) begin
         return 18'sd131071;
      end else if (v < -20'sd131072) begin
         return -18'sd131072;
      end
      return 18'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

endpackage

// ===== rtl/core/radix2_fft_ifft_frame_core.sv =====
// Frame FFT/IFFT core. Complex 16-bit samples are taken one item at a time;
// when the last sample of a 2^log2_points frame arrives, the frame is
// bit-reversed, transformed in place with radix-2 butterflies (inverse: conjugate
// twiddles, then a rounded shift by log2_points) and each later item carries out
// one natural-order bin of that frame. The first frame gives no results and the
// last one is not flushed. An item is accepted only while the core is idle; once a
// spectrum exists, the next item is not taken until the bin of the last one has been
// loaded into the output register, later still while the previous result item is
// held. At frame end the core is busy copying, running the butterflies and, for the
// inverse, scaling, so throughput is set by the single butterfly unit sharing one
// write port of the work memory.
module radix2_fft_ifft_frame_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_real, sample_imag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // bin_index, bin_real, bin_imag, zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rfft_pkg::*;

   logic [3:0] log2_ff;
   logic       inv_ff;
   logic       csr_we;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= LOG2_RESET;
         inv_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_paddr[2])
            REG_LOG2: log2_ff <= csr_pwdata[3:0];
            REG_INV:  inv_ff  <= csr_pwdata[0];
            default:  log2_ff <= log2_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_INV) ? {31'd0, inv_ff} : {28'd0, log2_ff};

   rfft_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .cfg_log2    (log2_ff),
      .cfg_inverse (inv_ff),
      .status      (status),
      .cmd         (cmd)
   );

   rfft_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_result_held_while_stalled: assert property (
      @(posedge clock) disable iff (reset) rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_result_follows_item: assert property (
      @(posedge clock) disable iff (reset)
         $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result item appeared without a preceding input item");

endmodule

// ===== rtl/core/rfft_ctrl.sv =====
module rfft_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [3:0]          cfg_log2,
   input  logic                cfg_inverse,
   input  rfft_pkg::status_type status,
   output rfft_pkg::cmd_type   cmd
);
   import rfft_pkg::*;

   state_type   state_ff, state_in;
   logic [11:0] pos_ff, pos_in;
   logic [11:0] idx_ff, idx_in;
   logic [3:0]  stage_ff, stage_in;
   logic [3:0]  lsz_ff, lsz_in;
   logic [10:0] bf_ff, bf_in;
   logic        have_ff, have_in;
   logic        inv_ff, inv_in;
   logic        last_ff, last_in;
   logic [11:0] emit_idx_ff, emit_idx_in;

   logic [3:0]  l_now;
   logic [11:0] mask_now, mask_x, hmask, j, u, v, rev;
   logic        last_now, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         have_ff  <= have_in;
      end
      idx_ff      <= idx_in;
      stage_ff    <= stage_in;
      lsz_ff      <= lsz_in;
      bf_ff       <= bf_in;
      inv_ff      <= inv_in;
      last_ff     <= last_in;
      emit_idx_ff <= emit_idx_in;
   end

   always_comb begin
      if (cfg_log2 == 4'd0) begin
         l_now = 4'd1;
      end else if (cfg_log2 > 4'(MAX_LOG2)) begin
         l_now = 4'(MAX_LOG2);
      end else begin
         l_now = cfg_log2;
      end
      mask_now = 12'((13'd1 << l_now) - 13'd1);
      last_now = pos_ff >= mask_now;
      mask_x   = 12'((13'd1 << lsz_ff) - 13'd1);
      hmask    = 12'((13'd1 << (stage_ff - 4'd1)) - 13'd1);
      j        = {1'b0, bf_ff} & hmask;
      u        = 12'(({1'b0, bf_ff} & ~hmask) << 1) | j;
      v        = u | (hmask + 12'd1);
      for (int b = 0; b < MAX_LOG2; b++) begin
         rev[MAX_LOG2 - 1 - b] = idx_ff[b];
      end
      rev = rev >> (4'(MAX_LOG2) - lsz_ff);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      stage_in    = stage_ff;
      lsz_in      = lsz_ff;
      bf_in       = bf_ff;
      have_in     = have_ff;
      inv_in      = inv_ff;
      last_in     = last_ff;
      emit_idx_in = emit_idx_ff;

      cmd           = '0;
      cmd.wsel      = WSEL_COPY;
      cmd.load_wa   = pos_ff;
      cmd.load_ra   = idx_ff;
      cmd.work_ra   = u;
      cmd.work_rb   = v;
      cmd.work_wa   = u;
      cmd.tw_addr   = 11'(j << (4'(MAX_LOG2) - stage_ff));
      cmd.out_index = emit_idx_ff;
      cmd.out_last  = last_ff;
      cmd.shift     = lsz_ff;
      cmd.inverse   = inv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_we = 1'b1;
               cmd.work_re = have_ff;
               cmd.work_ra = pos_ff;
               emit_idx_in = pos_ff;
               last_in     = last_now;
               if (last_now) begin
                  pos_in  = '0;
                  lsz_in  = l_now;
                  inv_in  = cfg_inverse;
                  idx_in  = '0;
                  have_in = 1'b1;
               end else begin
                  pos_in = pos_ff + 12'd1;
               end
               if (have_ff) begin
                  state_in = ST_EMIT;
               end else if (last_now) begin
                  state_in = ST_CP_RD;
               end
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = last_ff ? ST_CP_RD : ST_IDLE;
            end
         end
         ST_CP_RD: begin
            cmd.load_re = 1'b1;
            state_in    = ST_CP_WR;
         end
         ST_CP_WR: begin
            cmd.work_we = 1'b1;
            cmd.work_wa = rev;
            cmd.wsel    = WSEL_COPY;
            if (idx_ff == mask_x) begin
               stage_in = 4'd1;
               bf_in    = '0;
               state_in = ST_BF_RD;
            end else begin
               idx_in   = idx_ff + 12'd1;
               state_in = ST_CP_RD;
            end
         end
         ST_BF_RD: begin
            cmd.work_re = 1'b1;
            cmd.tw_re   = 1'b1;
            state_in    = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_BF_ADD;
         end
         ST_BF_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = ST_BF_WU;
         end
         ST_BF_WU: begin
            cmd.work_we = 1'b1;
            cmd.wsel    = WSEL_BF_U;
            state_in    = ST_BF_WV;
         end
         ST_BF_WV: begin
            cmd.work_we = 1'b1;
            cmd.work_wa = v;
            cmd.wsel    = WSEL_BF_V;
            state_in    = ST_BF_RD;
            if (bf_ff == mask_x[11:1]) begin
               bf_in = '0;
               if (stage_ff == lsz_ff) begin
                  idx_in   = '0;
                  state_in = inv_ff ? ST_SC_RD : ST_IDLE;
               end else begin
                  stage_in = stage_ff + 4'd1;
               end
            end else begin
               bf_in = bf_ff + 11'd1;
            end
         end
         ST_SC_RD: begin
            cmd.work_re = 1'b1;
            cmd.work_ra = idx_ff;
            state_in    = ST_SC_WR;
         end
         ST_SC_WR: begin
            cmd.work_we = 1'b1;
            cmd.work_wa = idx_ff;
            cmd.wsel    = WSEL_SCALE;
            if (idx_ff == mask_x) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 12'd1;
               state_in = ST_SC_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rfft_dp.sv =====
module rfft_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rfft_pkg::cmd_type    cmd,
   output rfft_pkg::status_type status,
   input  logic [31:0]          sample,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [79:0]          rsp_tdata,
   output logic                 rsp_tlast
);
   import rfft_pkg::*;

   localparam tw_rom_type TW_ROM = build_tw_rom();

   logic [31:0] load_mem_ff [MAX_POINTS];
   logic [63:0] work_mem_ff [MAX_POINTS];

   logic [31:0]        load_q_ff;
   logic [63:0]        rda_ff, rdb_ff;
   logic [37:0]        tw_ff;
   logic signed [49:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [63:0]        bu_ff, bv_ff;
   logic               out_valid_ff, out_valid_in;
   logic [75:0]        out_ff;
   logic               out_last_ff;

   logic signed [31:0] a_re, a_im, b_re, b_im;
   logic signed [18:0] tw_cos, tw_sin;
   logic signed [17:0] wr, wi;
   logic signed [50:0] sum_r, sum_i;
   logic signed [33:0] tr, ti;
   logic signed [32:0] bias;
   logic [63:0]        wdata, scaled, copied;

   always_comb begin
      a_re   = rda_ff[31:0];
      a_im   = rda_ff[63:32];
      b_re   = rdb_ff[31:0];
      b_im   = rdb_ff[63:32];
      tw_cos = tw_ff[18:0];
      tw_sin = tw_ff[37:19];
      wr     = sat_tw(20'(tw_cos));
      wi     = cmd.inverse ? sat_tw(20'(tw_sin)) : sat_tw(-20'(tw_sin));
      sum_r  = 51'(p_rr_ff) - 51'(p_ii_ff) + 51'sd65536;
      sum_i  = 51'(p_ri_ff) + 51'(p_ir_ff) + 51'sd65536;
      tr     = 34'(sum_r >>> TW_FRAC);
      ti     = 34'(sum_i >>> TW_FRAC);
      bias   = 33'sd1 <<< (cmd.shift - 4'd1);
      scaled = {32'((33'(a_im) + bias) >>> cmd.shift),
                32'((33'(a_re) + bias) >>> cmd.shift)};
      copied = {32'(signed'(load_q_ff[31:16])), 32'(signed'(load_q_ff[15:0]))};
      case (cmd.wsel)
         WSEL_COPY:  wdata = copied;
         WSEL_BF_U:  wdata = bu_ff;
         WSEL_BF_V:  wdata = bv_ff;
         WSEL_SCALE: wdata = scaled;
         default:    wdata = copied;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         load_mem_ff[cmd.load_wa] <= sample;
      end
      if (cmd.load_re) begin
         load_q_ff <= load_mem_ff[cmd.load_ra];
      end
      if (cmd.work_we) begin
         work_mem_ff[cmd.work_wa] <= wdata;
      end
      if (cmd.work_re) begin
         rda_ff <= work_mem_ff[cmd.work_ra];
         rdb_ff <= work_mem_ff[cmd.work_rb];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tw_re) begin
         tw_ff <= TW_ROM[cmd.tw_addr];
      end
      if (cmd.mul_en) begin
         p_rr_ff <= b_re * wr;
         p_ii_ff <= b_im * wi;
         p_ri_ff <= b_re * wi;
         p_ir_ff <= b_im * wr;
      end
      if (cmd.add_en) begin
         bu_ff <= {sat32(35'(a_im) + 35'(ti)), sat32(35'(a_re) + 35'(tr))};
         bv_ff <= {sat32(35'(a_im) - 35'(ti)), sat32(35'(a_re) - 35'(tr))};
      end
      if (cmd.out_load) begin
         out_ff      <= {rda_ff[63:32], rda_ff[31:0], cmd.out_index};
         out_last_ff <= cmd.out_last;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.rsp_busy = out_valid_ff && !rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = {4'd0, out_ff};
   assign rsp_tlast       = out_last_ff;

endmodule

// ===== test/tb_radix2_fft_ifft_frame_core.sv =====
`timescale 1ns / 100ps

module tb_radix2_fft_ifft_frame_core;

   localparam logic [2:0] ADDR_LOG2 = 3'd0;
   localparam logic [2:0] ADDR_INV  = 3'd4;
   localparam int         NPTS      = 4096;

   typedef struct {
      logic [11:0]        index;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               last;
   } bin_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // sample_real, sample_imag
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // bin_index, bin_real, bin_imag, zero fill
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   radix2_fft_ifft_frame_core u_dut (.*);

   always #5 clock = ~clock;

   logic [31:0] sample_queue[$];
   bin_type     bin_queue[$];
   int          send_idle_pct = 27;
   int          recv_idle_pct = 86;
   int          mismatches = 0;
   int          samples_sent = 0;
   int          bins_checked = 0;

   // Predicted block state.
   int          load_re[NPTS], load_im[NPTS];
   int          spec_re[NPTS], spec_im[NPTS];
   longint      work_re[NPTS], work_im[NPTS];
   int          tw_cos[NPTS/2], tw_sin[NPTS/2];
   int          frame_pos = 0;
   bit          spectrum_ready = 0;
   int          size_reg = 10;
   bit          inverse_reg = 0;
   bit          frame_closed = 0;

   function automatic longint round_bits(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp_tw(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic int effective_log2();
      int l;
      l = (size_reg == 0) ? 1 : size_reg;
      return (l > 12) ? 12 : l;
   endfunction

   task automatic run_transform(int lg);
      int n, r, len, half, stride, k, u, v;
      longint wr, wi, tr, ti, ur, ui;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         r = 0;
         for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
         work_re[r] = load_re[i];
         work_im[r] = load_im[i];
      end
      for (int s = 1; s <= lg; s++) begin
         len = 1 << s;
         half = len >> 1;
         stride = NPTS >> s;
         for (int base = 0; base < n; base += len) begin
            for (int j = 0; j < half; j++) begin
               k = (j * stride) & (NPTS/2 - 1);
               wr = clamp_tw(tw_cos[k]);
               wi = clamp_tw(inverse_reg ? longint'(tw_sin[k]) : -longint'(tw_sin[k]));
               u = base + j;
               v = u + half;
               tr = round_bits(work_re[v] * wr - work_im[v] * wi, 17);
               ti = round_bits(work_re[v] * wi + work_im[v] * wr, 17);
               ur = work_re[u];
               ui = work_im[u];
               work_re[v] = clamp32(ur - tr);
               work_im[v] = clamp32(ui - ti);
               work_re[u] = clamp32(ur + tr);
               work_im[u] = clamp32(ui + ti);
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         if (inverse_reg) begin
            work_re[i] = round_bits(work_re[i], lg);
            work_im[i] = round_bits(work_im[i], lg);
         end
         spec_re[i] = int'(clamp32(work_re[i]));
         spec_im[i] = int'(clamp32(work_im[i]));
      end
   endtask

   task automatic take_sample(logic [31:0] data);
      int lg, p;
      bit last;
      bin_type b;
      lg = effective_log2();
      p = frame_pos & (NPTS - 1);
      last = p >= (1 << lg) - 1;
      if (spectrum_ready) begin
         b.index = p[11:0];
         b.re = spec_re[p];
         b.im = spec_im[p];
         b.last = last;
         bin_queue.push_back(b);
      end
      load_re[p] = int'($signed(data[15:0]));
      load_im[p] = int'($signed(data[31:16]));
      frame_closed = last;
      if (last) begin
         run_transform(lg);
         spectrum_ready = 1;
         frame_pos = 0;
      end else begin
         frame_pos = p + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata);
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= sample_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      bin_type b;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (bin_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected bin %0d", rsp_tdata[11:0]);
            end else begin
               b = bin_queue.pop_front();
               bins_checked++;
               if (rsp_tdata[11:0] !== b.index || rsp_tdata[43:12] !== b.re ||
                   rsp_tdata[75:44] !== b.im || rsp_tlast !== b.last ||
                   rsp_tdata[79:76] !== 4'd0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Bin mismatch: expected %0d (%0d,%0d) last %0b, ",
                               "got %0d (%0d,%0d) last %0b"},
                              b.index, b.re, b.im, b.last, rsp_tdata[11:0],
                              $signed(rsp_tdata[43:12]), $signed(rsp_tdata[75:44]),
                              rsp_tlast);
               end
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_LOG2) size_reg = value[3:0];
      else inverse_reg = value[0];
   endtask

   task automatic configure(int lg, bit inv);
      csr_write(ADDR_LOG2, lg);
      csr_write(ADDR_INV, inv);
   endtask

   // Waits until every item is taken and every bin has come, then lets the
   // transform finish when the last item closed a frame.
   task automatic drain();
      int n, lg;
      while (sample_queue.size() > 0 || req_tvalid || bin_queue.size() > 0)
         @(posedge clock);
      lg = effective_log2();
      n = 1 << lg;
      repeat (frame_closed ? (4 * n + 3 * n * lg + 64) : 16) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_part();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom_range(16'hffff));
      endcase
   endfunction

   task automatic add_random(int count);
      for (int i = 0; i < count; i++) sample_queue.push_back({pick_part(), pick_part()});
   endtask

   initial begin
      for (int k = 0; k < NPTS/2; k++) begin
         real a;
         int kq;
         if (4 * k < NPTS) begin
            a = 2.0 * 3.141592653589793 * k / NPTS;
            tw_cos[k] = $rtoi($floor($cos(a) * 131072.0 + 0.5));
            tw_sin[k] = $rtoi($floor($sin(a) * 131072.0 + 0.5));
         end else begin
            kq = k - NPTS / 4;
            a = 2.0 * 3.141592653589793 * kq / NPTS;
            tw_cos[k] = -$rtoi($floor($sin(a) * 131072.0 + 0.5));
            tw_sin[k] = $rtoi($floor($cos(a) * 131072.0 + 0.5));
         end
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A 128-point first frame fills every bin that the later, smaller sizes read.
      configure(7, 0);
      add_random(128);
      drain();

      configure(3, 0);
      sample_queue.push_back({16'h0000, 16'h7fff});
      repeat (7) sample_queue.push_back(32'h0);
      sample_queue.push_back({16'h8000, 16'h8000});
      sample_queue.push_back({16'h7fff, 16'h7fff});
      sample_queue.push_back({16'h7fff, 16'h8000});
      sample_queue.push_back({16'h8000, 16'h7fff});
      sample_queue.push_back({16'hffff, 16'h0001});
      sample_queue.push_back({16'h5555, 16'haaaa});
      sample_queue.push_back({16'haaaa, 16'h5555});
      sample_queue.push_back({16'h0001, 16'hffff});
      drain();

      // Oversized setting, then a shrink that closes the frame early.
      configure(14, 1);
      add_random(5);
      drain();
      csr_write(ADDR_LOG2, 2);
      add_random(5);
      drain();
      configure(0, 1);
      add_random(8);
      drain();

      send_idle_pct = 86;
      recv_idle_pct = 27;
      for (int ph = 0; ph < 4; ph++) begin
         configure($urandom_range(1, 6), 1'($urandom_range(1)));
         add_random($urandom_range(30, 60));
         drain();
      end

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int ph = 0; ph < 3; ph++) begin
         configure($urandom_range(1, 7), 1'($urandom_range(1)));
         add_random($urandom_range(30, 60));
         drain();
      end
      configure(1, 0);
      add_random(20);
      drain();

      $display("Sent %0d samples over sizes 2 to 128 points plus an oversized setting,",
               samples_sent);
      $display("forward and inverse, and checked %0d bins with %0d mismatches.",
               bins_checked, mismatches);
      if (mismatches == 0 && bin_queue.size() == 0) begin
         $display("radix2_fft_ifft_frame_core test passed");
      end else begin
         $display("radix2_fft_ifft_frame_core test failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("radix2_fft_ifft_frame_core test failed");
      $finish;
   end

endmodule
